### sv/ps2a_pkg.sv
`default_nettype none

package ps2a_pkg;

   localparam int unsigned ScanWidth = 8;
   localparam int unsigned CharWidth = 7;
   localparam int unsigned RomAddrWidth = 6;

   localparam logic [7:0] PrefixByte = 8'hE0;
   localparam logic [6:0] KeyCtrl = 7'h1D;
   localparam logic [6:0] KeyShiftLeft = 7'h2A;
   localparam logic [6:0] KeyShiftRight = 7'h36;
   localparam logic [6:0] KeyAlt = 7'h38;
   localparam logic [6:0] KeyCaps = 7'h3A;
   localparam logic [6:0] KeyCount = 7'h3B;

   typedef struct packed {
      logic [CharWidth-1:0] plain;
      logic [CharWidth-1:0] shifted;
   } rom_word_type;

   typedef struct packed {
      logic valid;
      logic [CharWidth-1:0] char_code;
      logic unknown_key;
      logic ctrl_held;
      logic alt_held;
   } result_type;

   function automatic logic is_symbol_key(input logic [6:0] code);
      is_symbol_key = (code < 7'h0E) || (code == 7'h29) || (code == 7'h1A) ||
                      (code == 7'h1B) || (code == 7'h2B) || (code == 7'h27) ||
                      (code == 7'h28) || (code == 7'h33) || (code == 7'h34) ||
                      (code == 7'h35);
   endfunction

endpackage

`default_nettype wire

### sv/ps2_set1_scancode_to_ascii_top.sv
// PS/2 scan code set 1 to ASCII decoder.
// req_ carries one raw keyboard byte per word in req_tdata[7:0].
// rsp_ carries at most one word per input byte: the ASCII character and the
// current ctrl and alt modifier state in rsp_tdata, and in rsp_tuser a flag
// that marks a make code outside the mapped key set.
// Prefix bytes, break codes and modifier or caps lock makes give no word.
// A byte is held first in the key ROM read stage and then in the output
// register. One byte is taken every cycle while the output is not stalled;
// the rate is set by the synchronous ROM read followed by the flag update
// in the decode stage.
// When rsp_tready is low the output register holds its word, the ROM stage
// still accepts one more byte, and req_tready drops until the output drains.
// Synchronous reset clears the prefix, ctrl, shift, alt and caps lock flags
// and empties both stages.
`default_nettype none

module ps2_set1_scancode_to_ascii_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [6:0] char_code, [7] ctrl_held, [8] alt_held
   output logic             rsp_tuser    // [0] unknown_key
);

   logic s1_valid_ff, s1_valid_in;
   logic [ps2a_pkg::ScanWidth-1:0] s1_byte_ff;
   logic out_valid_ff, out_valid_in;
   ps2a_pkg::result_type out_ff;
   ps2a_pkg::rom_word_type rom_word;
   ps2a_pkg::result_type result;
   logic out_free;
   logic step;
   logic accept;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   ps2a_key_rom u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_tdata[ps2a_pkg::RomAddrWidth-1:0]),
      .rd_data (rom_word)
   );

   ps2a_decoder u_dec (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .scan_byte (s1_byte_ff),
      .rom_word  (rom_word),
      .result    (result)
   );

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !out_free);
      if (out_free) begin
         out_valid_in = step && result.valid;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_tdata;
      end
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.alt_held, out_ff.ctrl_held, out_ff.char_code};
   assign rsp_tuser  = out_ff.unknown_key;

endmodule

`default_nettype wire

### sv/ps2a_key_rom.sv
`default_nettype none

module ps2a_key_rom (
   input  wire logic                                clock,
   input  wire logic                                rd_en,
   input  wire logic [ps2a_pkg::RomAddrWidth-1:0]   rd_addr,
   output ps2a_pkg::rom_word_type                   rd_data
);

   ps2a_pkg::rom_word_type rd_data_ff;
   ps2a_pkg::rom_word_type rd_data_in;

   always_comb begin
      unique case (rd_addr)
         6'h01: rd_data_in = '{7'h1B, 7'h1B};
         6'h02: rd_data_in = '{7'h31, 7'h21};
         6'h03: rd_data_in = '{7'h32, 7'h40};
         6'h04: rd_data_in = '{7'h33, 7'h23};
         6'h05: rd_data_in = '{7'h34, 7'h24};
         6'h06: rd_data_in = '{7'h35, 7'h25};
         6'h07: rd_data_in = '{7'h36, 7'h5E};
         6'h08: rd_data_in = '{7'h37, 7'h26};
         6'h09: rd_data_in = '{7'h38, 7'h2A};
         6'h0A: rd_data_in = '{7'h39, 7'h28};
         6'h0B: rd_data_in = '{7'h30, 7'h29};
         6'h0C: rd_data_in = '{7'h2D, 7'h5F};
         6'h0D: rd_data_in = '{7'h3D, 7'h2B};
         6'h0E: rd_data_in = '{7'h08, 7'h08};
         6'h0F: rd_data_in = '{7'h09, 7'h09};
         6'h10: rd_data_in = '{7'h71, 7'h51};
         6'h11: rd_data_in = '{7'h77, 7'h57};
         6'h12: rd_data_in = '{7'h65, 7'h45};
         6'h13: rd_data_in = '{7'h72, 7'h52};
         6'h14: rd_data_in = '{7'h74, 7'h54};
         6'h15: rd_data_in = '{7'h79, 7'h59};
         6'h16: rd_data_in = '{7'h75, 7'h55};
         6'h17: rd_data_in = '{7'h69, 7'h49};
         6'h18: rd_data_in = '{7'h6F, 7'h4F};
         6'h19: rd_data_in = '{7'h70, 7'h50};
         6'h1A: rd_data_in = '{7'h5B, 7'h7B};
         6'h1B: rd_data_in = '{7'h5D, 7'h7D};
         6'h1C: rd_data_in = '{7'h0D, 7'h0D};
         6'h1E: rd_data_in = '{7'h61, 7'h41};
         6'h1F: rd_data_in = '{7'h73, 7'h53};
         6'h20: rd_data_in = '{7'h64, 7'h44};
         6'h21: rd_data_in = '{7'h66, 7'h46};
         6'h22: rd_data_in = '{7'h67, 7'h47};
         6'h23: rd_data_in = '{7'h68, 7'h48};
         6'h24: rd_data_in = '{7'h6A, 7'h4A};
         6'h25: rd_data_in = '{7'h6B, 7'h4B};
         6'h26: rd_data_in = '{7'h6C, 7'h4C};
         6'h27: rd_data_in = '{7'h3B, 7'h3A};
         6'h28: rd_data_in = '{7'h27, 7'h22};
         6'h29: rd_data_in = '{7'h60, 7'h7E};
         6'h2B: rd_data_in = '{7'h5C, 7'h7C};
         6'h2C: rd_data_in = '{7'h7A, 7'h5A};
         6'h2D: rd_data_in = '{7'h78, 7'h58};
         6'h2E: rd_data_in = '{7'h63, 7'h43};
         6'h2F: rd_data_in = '{7'h76, 7'h56};
         6'h30: rd_data_in = '{7'h62, 7'h42};
         6'h31: rd_data_in = '{7'h6E, 7'h4E};
         6'h32: rd_data_in = '{7'h6D, 7'h4D};
         6'h33: rd_data_in = '{7'h2C, 7'h3C};
         6'h34: rd_data_in = '{7'h2E, 7'h3E};
         6'h35: rd_data_in = '{7'h2F, 7'h3F};
         6'h37: rd_data_in = '{7'h2A, 7'h2A};
         6'h39: rd_data_in = '{7'h20, 7'h20};
         default: rd_data_in = '{7'h00, 7'h00};
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rd_data_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/ps2a_decoder.sv
`default_nettype none

module ps2a_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic [ps2a_pkg::ScanWidth-1:0]      scan_byte,
   input  wire ps2a_pkg::rom_word_type              rom_word,
   output ps2a_pkg::result_type                     result
);

   logic prefix_ff, prefix_in;
   logic ctrl_ff, ctrl_in;
   logic shift_ff, shift_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;

   logic [6:0] low;
   logic       mapped;
   logic       col;
   logic [ps2a_pkg::CharWidth-1:0] ch;

   assign low = scan_byte[6:0];

   always_comb begin
      prefix_in = prefix_ff;
      ctrl_in   = ctrl_ff;
      shift_in  = shift_ff;
      alt_in    = alt_ff;
      caps_in   = caps_ff;
      result    = '0;
      mapped    = prefix_ff ? ((low == ps2a_pkg::KeyAlt) || (low == ps2a_pkg::KeyCtrl))
                            : ((low != 7'h00) && (low < ps2a_pkg::KeyCount));
      col       = (!prefix_ff && ps2a_pkg::is_symbol_key(low)) ? shift_ff
                                                                : (shift_ff ^ caps_ff);
      ch        = col ? rom_word.shifted : rom_word.plain;
      if (scan_byte == ps2a_pkg::PrefixByte) begin
         prefix_in = 1'b1;
      end else begin
         prefix_in = 1'b0;
         if (scan_byte[7]) begin
            priority if (low == ps2a_pkg::KeyCtrl) begin
               ctrl_in = 1'b0;
            end else if (!prefix_ff && ((low == ps2a_pkg::KeyShiftLeft) ||
                                        (low == ps2a_pkg::KeyShiftRight))) begin
               shift_in = 1'b0;
            end else if (low == ps2a_pkg::KeyAlt) begin
               alt_in = 1'b0;
            end else begin
               ctrl_in = ctrl_ff;
            end
         end else if (mapped) begin
            if (ch != '0) begin
               result = '{1'b1, ch, 1'b0, ctrl_ff, alt_ff};
            end else begin
               priority if (low == ps2a_pkg::KeyCtrl) begin
                  ctrl_in = 1'b1;
               end else if ((low == ps2a_pkg::KeyShiftLeft) ||
                            (low == ps2a_pkg::KeyShiftRight)) begin
                  shift_in = 1'b1;
               end else if (low == ps2a_pkg::KeyAlt) begin
                  alt_in = 1'b1;
               end else if (low == ps2a_pkg::KeyCaps) begin
                  caps_in = !caps_ff;
               end else begin
                  caps_in = caps_ff;
               end
            end
         end else begin
            result = '{1'b1, 7'd0, 1'b1, ctrl_ff, alt_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
         ctrl_ff   <= 1'b0;
         shift_ff  <= 1'b0;
         alt_ff    <= 1'b0;
         caps_ff   <= 1'b0;
      end else if (step) begin
         prefix_ff <= prefix_in;
         ctrl_ff   <= ctrl_in;
         shift_ff  <= shift_in;
         alt_ff    <= alt_in;
         caps_ff   <= caps_in;
      end
   end

endmodule

`default_nettype wire

### sim/ps2_set1_scancode_to_ascii_top_tb.sv
`timescale 1ns / 100ps

module ps2_set1_scancode_to_ascii_top_tb;

   localparam int HoldOffCycles = 200;
   localparam int SettleCycles = 4;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [6:0] char_code;
      logic       unknown_key;
      logic       ctrl_held;
      logic       alt_held;
   } decoded_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] scan_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [6:0] char_code, [7] ctrl_held, [8] alt_held
   logic        rsp_tuser;          // [0] unknown_key

   logic [7:0] plain_rom [0:58] = '{
      8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8, 8'd9,
      "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd13, 8'd0,
      "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'd0, 8'h5C,
      "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " ", 8'd0
   };

   logic [7:0] shifted_rom [0:58] = '{
      8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8, 8'd9,
      "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd13, 8'd0,
      "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'd0, "|",
      "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " ", 8'd0
   };

   logic ext_armed = 1'b0;
   logic ctrl_flag = 1'b0;
   logic shift_flag = 1'b0;
   logic alt_flag = 1'b0;
   logic caps_flag = 1'b0;

   decoded_word_type pending_chars[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_req = 1'b0;
   int hold_left = 0;

   int bytes_sent = 0;
   int words_checked = 0;
   int mismatches = 0;

   ps2_set1_scancode_to_ascii_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_punct_key(input logic [6:0] key);
      case (key)
         7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29, 7'h2B, 7'h33, 7'h34, 7'h35: return 1'b1;
         default: return key < 7'h0E;
      endcase
   endfunction

   function automatic void decode_scan(input logic [7:0] scan);
      logic ext;
      logic upper;
      logic [7:0] ch;
      decoded_word_type w;
      if (scan == ps2a_pkg::PrefixByte) begin
         ext_armed = 1'b1;
         return;
      end
      ext = ext_armed;
      ext_armed = 1'b0;
      if (scan[7]) begin
         if (scan[6:0] == ps2a_pkg::KeyCtrl) begin
            ctrl_flag = 1'b0;
         end else if (!ext && (scan[6:0] == ps2a_pkg::KeyShiftLeft ||
                               scan[6:0] == ps2a_pkg::KeyShiftRight)) begin
            shift_flag = 1'b0;
         end else if (scan[6:0] == ps2a_pkg::KeyAlt) begin
            alt_flag = 1'b0;
         end
      end else if ((!ext && scan != 8'd0 && scan[6:0] < ps2a_pkg::KeyCount) ||
                   (ext && (scan[6:0] == ps2a_pkg::KeyAlt ||
                            scan[6:0] == ps2a_pkg::KeyCtrl))) begin
         upper = (!ext && is_punct_key(scan[6:0])) ? shift_flag : (shift_flag ^ caps_flag);
         ch = upper ? shifted_rom[scan[5:0]] : plain_rom[scan[5:0]];
         if (ch != 8'd0) begin
            w = '{ch[6:0], 1'b0, ctrl_flag, alt_flag};
            pending_chars.push_back(w);
         end else if (scan[6:0] == ps2a_pkg::KeyCtrl) begin
            ctrl_flag = 1'b1;
         end else if (scan[6:0] == ps2a_pkg::KeyShiftLeft ||
                      scan[6:0] == ps2a_pkg::KeyShiftRight) begin
            shift_flag = 1'b1;
         end else if (scan[6:0] == ps2a_pkg::KeyAlt) begin
            alt_flag = 1'b1;
         end else if (scan[6:0] == ps2a_pkg::KeyCaps) begin
            caps_flag = ~caps_flag;
         end
      end else begin
         w = '{7'd0, 1'b1, ctrl_flag, alt_flag};
         pending_chars.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left <= HoldOffCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      decoded_word_type want;
      decoded_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[6:0], rsp_tuser, rsp_tdata[7], rsp_tdata[8]};
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("unexpected word: char %02h unknown %b ctrl %b alt %b",
                        got.char_code, got.unknown_key, got.ctrl_held, got.alt_held);
         end else begin
            want = pending_chars.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("word %0d: expected char %02h unknown %b ctrl %b alt %b, %s",
                           words_checked, want.char_code, want.unknown_key,
                           want.ctrl_held, want.alt_held,
                           $sformatf("got char %02h unknown %b ctrl %b alt %b",
                                     got.char_code, got.unknown_key,
                                     got.ctrl_held, got.alt_held));
            end
         end
         words_checked++;
      end
   end

   task automatic send_scan(input logic [7:0] scan);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= scan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_scan(scan);
      bytes_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_key_event();
      int pick;
      logic [7:0] key;
      pick = $urandom_range(99);
      if (pick < 50) begin
         key = 8'($urandom_range(58, 1));
         send_scan(key);
         if ($urandom_range(1) == 1) send_scan(key | 8'h80);
      end else if (pick < 65) begin
         case ($urandom_range(4))
            0: key = {1'b0, ps2a_pkg::KeyCtrl};
            1: key = {1'b0, ps2a_pkg::KeyShiftLeft};
            2: key = {1'b0, ps2a_pkg::KeyShiftRight};
            3: key = {1'b0, ps2a_pkg::KeyAlt};
            default: key = {1'b0, ps2a_pkg::KeyCaps};
         endcase
         if ((key[6:0] == ps2a_pkg::KeyCtrl || key[6:0] == ps2a_pkg::KeyAlt) &&
             $urandom_range(1) == 1)
            send_scan(ps2a_pkg::PrefixByte);
         if ($urandom_range(1) == 1) key = key | 8'h80;
         send_scan(key);
      end else if (pick < 75) begin
         send_scan(ps2a_pkg::PrefixByte);
         send_scan(8'($urandom_range(255)));
      end else begin
         send_scan(8'($urandom_range(255)));
      end
   endtask

   task automatic test_plain_keys();
      logic [7:0] seq [0:7];
      seq = '{8'h00, 8'h01, 8'h02, 8'h0E, 8'h2B, 8'h39, 8'h3B, 8'h7F};
      foreach (seq[i]) send_scan(seq[i]);
      settle();
   endtask

   task automatic test_modifiers();
      logic [7:0] seq [0:26];
      seq = '{8'h3A, 8'h10, 8'h2A, 8'hE0, 8'hAA, 8'h10, 8'h02, 8'hAA, 8'h3A,
              8'h1D, 8'h38, 8'h1E, 8'h9D, 8'hB8, 8'hE0, 8'h1D, 8'hE0, 8'h38,
              8'h1E, 8'hE0, 8'h9D, 8'hE0, 8'hB8, 8'hE0, 8'hE0, 8'h35, 8'hFF};
      foreach (seq[i]) send_scan(seq[i]);
      settle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
      int stop_at;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_key_event();
      settle();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (30) send_scan(8'($urandom_range(8'h32, 8'h10)));
      settle();
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_keys();
      test_modifiers();
      test_random_traffic(0, 0, 250);
      test_random_traffic(55, 0, 250);
      test_random_traffic(0, 55, 250);
      test_random_traffic(15, 15, 250);
      test_output_backpressure();
      mismatches += pending_chars.size();
      $display("sent %0d scan bytes and checked %0d decoded words", bytes_sent, words_checked);
      $display("ran plain keys, modifier sequences, four idle mixes and a long output stall");
      if (mismatches == 0) begin
         $display("ps2_set1_scancode_to_ascii_top_tb: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("ps2_set1_scancode_to_ascii_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d words outstanding", pending_chars.size());
      $display("ps2_set1_scancode_to_ascii_top_tb: FAIL");
      $finish;
   end

endmodule
